FILE: rtl/iel_pkg.sv
// Shared types and constants for the information element locator.
package iel_pkg;

    // Default for the longest message the walk looks at.
    localparam int MAX_MSG_BYTES_DEF = 256;

    // Entries in the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] FIXED_MASK  = 8'h80;
    localparam logic [7:0] NIBBLE_MASK = 8'hF0;
    localparam logic [7:0] DOUBLE_CODE = 8'hE0;

    typedef enum logic [1:0] {
        PH_ID   = 2'd0,
        PH_LEN  = 2'd1,
        PH_SKIP = 2'd2
    } t_phase;

    // One classified byte as it travels through the queue.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       hit;
        logic       fixed;
        logic       double;
    } t_item;

endpackage

FILE: rtl/info_element_locator_top.sv
// A byte is queued on its transfer and walked when it heads the queue and the result
// slot is free or draining; a message's result is shown the cycle after its last
// byte is walked. Throughput: one byte per cycle while the result slot is free or
// draining; the walk of each byte is a single phase update, and a two-entry queue
// takes input transfers while a result waits, until full. Reset: synchronous,
// active low; clears queue, walk, result slot and target identifier (to zero).
module info_element_locator_top
    import iel_pkg::*;
#(
    parameter int MAX_MSG_BYTES = MAX_MSG_BYTES_DEF,
    localparam int POS_W = $clog2(MAX_MSG_BYTES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Configuration: target identifier
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_data,
    // Byte stream in
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    // Result out, one per message
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_found,
    output logic [POS_W-1:0] o_value_offset,
    output logic [7:0]       o_value_len
);

    logic [7:0] r_target_id;
    t_item      front_item;
    t_item      head_item;
    logic       q_full;
    logic       q_empty;
    logic       q_push;
    logic       q_pop;

    // Hold the target identifier; the user must write it only between messages; not enforced here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_id <= 8'h00;
        end else if (i_cfg_we) begin
            r_target_id <= i_cfg_data;
        end
    end

    // Take a transfer whenever the queue has room.
    assign o_ready = !q_full;
    assign q_push  = i_valid && !q_full;

    // Classify each byte on its way in: identifier hit, fixed, double-octet.
    iel_front u_front (
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_target_id (r_target_id),
        .o_item      (front_item)
    );

    // Decouple the input side from the walk and the result slot.
    iel_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (head_item)
    );

    // Walk the elements and register one result at each final byte.
    iel_back #(
        .MAX_MSG_BYTES (MAX_MSG_BYTES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_item         (head_item),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_found        (o_found),
        .o_value_offset (o_value_offset),
        .o_value_len    (o_value_len)
    );

endmodule

FILE: rtl/iel_front.sv
// Front part: classifies each incoming byte against the target identifier.
module iel_front
    import iel_pkg::*;
(
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic [7:0] i_target_id,
    output t_item      o_item
);

    always_comb begin
        o_item.data   = i_data_byte;
        o_item.last   = i_last_byte;
        o_item.hit    = (i_data_byte == i_target_id);
        o_item.fixed  = ((i_data_byte & FIXED_MASK) != 8'h00);
        o_item.double = ((i_data_byte & NIBBLE_MASK) == DOUBLE_CODE);
    end

endmodule

FILE: rtl/iel_queue.sv
// Short queue of classified bytes between the front and back parts.
module iel_queue
    import iel_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

FILE: rtl/iel_back.sv
// Back part: walks the element structure and registers the per-message result.
module iel_back
    import iel_pkg::*;
#(
    parameter int MAX_MSG_BYTES = MAX_MSG_BYTES_DEF,
    localparam int POS_W = $clog2(MAX_MSG_BYTES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  t_item            i_item,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_found,
    output logic [POS_W-1:0] o_value_offset,
    output logic [7:0]       o_value_len
);

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_MSG_BYTES);

    t_phase           r_phase, n_phase;
    logic [7:0]       r_skip, n_skip;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_match, n_match;
    logic             r_pending, n_pending;
    logic             r_stopped, n_stopped;
    logic [POS_W-1:0] r_moff, n_moff;
    logic [7:0]       r_mlen, n_mlen;

    logic             r_out_valid;
    logic             r_found;
    logic [POS_W-1:0] r_offset;
    logic [7:0]       r_len;

    logic             res_found;
    logic [POS_W-1:0] res_offset;
    logic [7:0]       res_len;
    logic             in_range;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       skip_dec;

    // Advance only when the result slot is free or being drained.
    assign o_pop    = !i_empty && (!r_out_valid || i_ready);
    assign in_range = (r_pos < POS_LIMIT);
    assign pos_next = r_pos + 1'b1;
    assign skip_dec = (r_skip != 8'h00) ? r_skip - 1'b1 : r_skip;

    // Next walk state for the byte at the head of the queue.
    always_comb begin
        n_phase   = r_phase;
        n_skip    = r_skip;
        n_pos     = r_pos;
        n_match   = r_match;
        n_pending = r_pending;
        n_stopped = r_stopped;
        n_moff    = r_moff;
        n_mlen    = r_mlen;
        if (o_pop) begin
            if (!r_stopped && in_range) begin
                unique case (r_phase)
                    PH_ID: begin
                        if (i_item.fixed) begin
                            n_pending = 1'b0;
                            if (i_item.hit) begin
                                n_match   = 1'b1;
                                n_stopped = 1'b1;
                                n_moff    = pos_next;
                                n_mlen    = {7'd0, i_item.double};
                            end else if (i_item.double) begin
                                n_skip  = 8'd1;
                                n_phase = PH_SKIP;
                            end
                        end else begin
                            n_pending = i_item.hit;
                            n_phase   = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        if (i_item.data == 8'h00) begin
                            if (r_pending) begin
                                n_match   = 1'b1;
                                n_stopped = 1'b1;
                                n_moff    = pos_next;
                                n_mlen    = 8'h00;
                            end
                            n_pending = 1'b0;
                            n_phase   = PH_ID;
                        end else begin
                            n_skip = i_item.data;
                            if (r_pending) begin
                                n_moff = pos_next;
                                n_mlen = i_item.data;
                            end
                            n_phase = PH_SKIP;
                        end
                    end
                    PH_SKIP: begin
                        n_skip = skip_dec;
                        if (skip_dec == 8'h00) begin
                            if (r_pending) begin
                                n_match   = 1'b1;
                                n_stopped = 1'b1;
                            end
                            n_pending = 1'b0;
                            n_phase   = PH_ID;
                        end
                    end
                    default: begin
                        n_phase = PH_ID;
                    end
                endcase
            end
            if (in_range) begin
                n_pos = pos_next;
            end
        end
    end

    // Result of the message, taken from the walk state after this byte.
    always_comb begin
        res_found  = n_match;
        res_offset = n_match ? n_moff : '0;
        res_len    = n_match ? n_mlen : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_ID;
            r_skip      <= '0;
            r_pos       <= '0;
            r_match     <= 1'b0;
            r_pending   <= 1'b0;
            r_stopped   <= 1'b0;
            r_moff      <= '0;
            r_mlen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && i_item.last) begin
                // Clear the walk for the next message.
                r_phase   <= PH_ID;
                r_skip    <= '0;
                r_pos     <= '0;
                r_match   <= 1'b0;
                r_pending <= 1'b0;
                r_stopped <= 1'b0;
                r_moff    <= '0;
                r_mlen    <= '0;
            end else begin
                r_phase   <= n_phase;
                r_skip    <= n_skip;
                r_pos     <= n_pos;
                r_match   <= n_match;
                r_pending <= n_pending;
                r_stopped <= n_stopped;
                r_moff    <= n_moff;
                r_mlen    <= n_mlen;
            end
            if (o_pop && i_item.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.last) begin
            r_found  <= res_found;
            r_offset <= res_offset;
            r_len    <= res_len;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_found        = r_found;
    assign o_value_offset = r_offset;
    assign o_value_len    = r_len;

endmodule

FILE: dv/tb_info_element_locator_top.sv
// Self-checking testbench for the information element locator top level.
module tb_info_element_locator_top
    import iel_pkg::*;
;

    // Cycles with no transfer on either channel before the run is declared hung.
    localparam int QUIET_LIMIT   = 2000;
    // Length of the forced receiver hold-off that backs the block up.
    localparam int HOLD_CYCLES   = 80;
    // Rough number of random bytes per configuration phase.
    localparam int PHASE_BYTES   = 56;
    localparam int NUM_PHASES    = 16;

    typedef logic [7:0] t_byte_q[$];

    // One lookup outcome as the block reports it at the end of a message.
    typedef struct packed {
        logic       found;
        logic [8:0] offset;
        logic [7:0] len;
    } t_locate_result;

    // Tracks the element walk byte by byte and holds the lookups still owed.
    class locate_scoreboard;
        logic [7:0]     target;
        t_phase         walk_phase;
        logic [7:0]     skip_left;
        int unsigned    pos;
        bit             matched;
        bit             pending;
        bit             halted;
        logic [8:0]     hit_offset;
        logic [7:0]     hit_len;
        t_locate_result lookups_due[$];
        int unsigned    n_errors;

        function new();
            target   = 8'h00;
            n_errors = 0;
            clear_walk();
        endfunction

        function void clear_walk();
            walk_phase = PH_ID;
            skip_left  = 8'd0;
            pos        = 0;
            matched    = 1'b0;
            pending    = 1'b0;
            halted     = 1'b0;
            hit_offset = 9'd0;
            hit_len    = 8'd0;
        endfunction

        function void take_hit(logic [8:0] off, logic [7:0] len);
            matched    = 1'b1;
            halted     = 1'b1;
            hit_offset = off;
            hit_len    = len;
        endfunction

        // Advance the walk by one accepted byte; queue a lookup on the last byte.
        function void note_byte(logic [7:0] b, logic l);
            logic           is_double;
            t_locate_result res;
            if (!halted && pos < MAX_MSG_BYTES_DEF) begin
                case (walk_phase)
                    PH_ID: begin
                        if ((b & FIXED_MASK) != 8'h00) begin
                            // Fixed element: the double-octet range carries one value byte.
                            is_double = ((b & NIBBLE_MASK) == DOUBLE_CODE);
                            pending   = 1'b0;
                            if (b == target) begin
                                take_hit(9'(pos + 1), {7'd0, is_double});
                            end else if (is_double) begin
                                skip_left  = 8'd1;
                                walk_phase = PH_SKIP;
                            end
                        end else begin
                            pending    = (b == target);
                            walk_phase = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        if (b == 8'd0) begin
                            if (pending) take_hit(9'(pos + 1), 8'd0);
                            pending    = 1'b0;
                            walk_phase = PH_ID;
                        end else begin
                            skip_left = b;
                            if (pending) begin
                                hit_offset = 9'(pos + 1);
                                hit_len    = b;
                            end
                            walk_phase = PH_SKIP;
                        end
                    end
                    default: begin
                        if (skip_left > 0) skip_left--;
                        if (skip_left == 0) begin
                            // A variable match only counts once its value is complete.
                            if (pending) take_hit(hit_offset, hit_len);
                            pending    = 1'b0;
                            walk_phase = PH_ID;
                        end
                    end
                endcase
            end
            if (pos < MAX_MSG_BYTES_DEF) pos++;
            if (l) begin
                res.found  = matched;
                res.offset = matched ? hit_offset : 9'd0;
                res.len    = matched ? hit_len : 8'd0;
                lookups_due.push_back(res);
                clear_walk();
            end
        endfunction

        function void report_field(string name, logic [8:0] want_v, logic [8:0] got_v);
            if (got_v !== want_v) begin
                n_errors++;
                if (n_errors <= 40)
                    $display("%0t: %s mismatch: expected %0d, actual %0d",
                             $time, name, want_v, got_v);
            end
        endfunction

        // Compare one delivered result with the oldest lookup owed.
        function void check_result(logic f, logic [8:0] off, logic [7:0] len);
            t_locate_result want;
            if (lookups_due.size() == 0) begin
                n_errors++;
                if (n_errors <= 40)
                    $display("%0t: unexpected result: found=%0d offset=%0d len=%0d",
                             $time, f, off, len);
                return;
            end
            want = lookups_due.pop_front();
            report_field("found", {8'd0, want.found}, {8'd0, f});
            report_field("value_offset", want.offset, off);
            report_field("value_len", {1'b0, want.len}, {1'b0, len});
        endfunction
    endclass

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_cfg_we       = 1'b0;
    logic [7:0] i_cfg_data     = 8'h00;
    logic       i_valid        = 1'b0;
    logic       o_ready;
    logic [7:0] i_data_byte    = 8'h00;
    logic       i_last_byte    = 1'b0;
    logic       o_valid;
    logic       i_ready        = 1'b0;
    logic       o_found;
    logic [8:0] o_value_offset;
    logic [7:0] o_value_len;

    locate_scoreboard sb = new();

    // Idle rates in percent, set per phase by the stimulus process.
    int unsigned gap_pct     = 0;
    int unsigned stall_pct   = 0;
    // Hold-off request picked up by the receiver process.
    int unsigned hold_req    = 0;
    int unsigned hold_left   = 0;
    int unsigned quiet_cycles = 0;

    info_element_locator_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_found        (o_found),
        .o_value_offset (o_value_offset),
        .o_value_len    (o_value_len)
    );

    always #4 i_clk = ~i_clk;

    // Receiver: stall at the phase rate, or hold ready low for a whole
    // hold-off stretch when one is requested so the block backs up.
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Monitor both channels on the pre-edge values: feed accepted bytes to the
    // predictor, check delivered results, and watch for a hang.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_byte(i_data_byte, i_last_byte);
            if (o_valid && i_ready)
                sb.check_result(o_found, o_value_offset, o_value_len);
        end
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offer one byte and hold it until the transfer; idle first at the gap rate.
    task automatic send_byte(input logic [7:0] b, input logic l);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= l;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_message(input t_byte_q m);
        for (int i = 0; i < m.size(); i++)
            send_byte(m[i], i == m.size() - 1);
    endtask

    // Drop valid, wait until every owed lookup has come back, then let the
    // pipeline settle.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.lookups_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the target identifier while the block is idle.
    task automatic write_target(input logic [7:0] t);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= t;
        @(posedge i_clk);
        sb.target = t;
        i_cfg_we <= 1'b0;
    endtask

    // Random identifier of one kind: fixed single-octet, double-octet or variable.
    function automatic logic [7:0] pick_id(int unsigned kind);
        logic [7:0] id;
        case (kind)
            0: begin
                do id = {1'b1, 7'($urandom)}; while ((id & NIBBLE_MASK) == DOUBLE_CODE);
            end
            1:       id = DOUBLE_CODE | 8'($urandom_range(15));
            default: id = {1'b0, 7'($urandom)};
        endcase
        return id;
    endfunction

    // Append a complete element; variable lengths are mostly short, now and
    // then up to the full byte range.
    function automatic void push_element(ref t_byte_q m, input logic [7:0] id);
        int unsigned len;
        m.push_back(id);
        if ((id & FIXED_MASK) != 8'h00) begin
            if ((id & NIBBLE_MASK) == DOUBLE_CODE) m.push_back(8'($urandom_range(255)));
        end else begin
            len = ($urandom_range(29) == 0) ? $urandom_range(255) : $urandom_range(5);
            m.push_back(8'(len));
            repeat (len) m.push_back(8'($urandom_range(255)));
        end
    endfunction

    // Mostly well-formed messages, most with the target planted somewhere; some are
    // overlong, and the rest are raw noise or cut short at a random byte.
    function automatic t_byte_q make_message(logic [7:0] tgt, bit overlong);
        t_byte_q     m;
        int unsigned n_elem;
        int unsigned tpos;
        int unsigned cut;
        int unsigned r;
        bit          plant;
        n_elem = $urandom_range(1, 5);
        tpos   = $urandom_range(0, n_elem - 1);
        plant  = ($urandom_range(99) < 60);
        for (int i = 0; i < n_elem; i++) begin
            if (plant && i == tpos) push_element(m, tgt);
            else push_element(m, pick_id($urandom_range(2)));
        end
        // A second copy of the target must be ignored after the first match.
        if ($urandom_range(4) == 0) push_element(m, tgt);
        if (overlong || $urandom_range(149) == 0) begin
            cut = 260 + $urandom_range(40);
            while (m.size() < cut) begin
                if ($urandom_range(7) == 0) push_element(m, tgt);
                else push_element(m, pick_id($urandom_range(2)));
            end
            while (m.size() > cut) void'(m.pop_back());
            return m;
        end
        r = $urandom_range(99);
        if (r < 12) begin
            m.delete();
            repeat ($urandom_range(1, 12)) m.push_back(8'($urandom_range(255)));
        end else if (r < 27) begin
            cut = $urandom_range(1, m.size());
            while (m.size() > cut) void'(m.pop_back());
        end
        return m;
    endfunction

    initial begin
        t_byte_q     msg;
        logic [7:0]  tgt;
        int unsigned sent;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, target still at its reset value of zero.
        // Zero-length variable element: found with no value bytes.
        msg = {8'h00, 8'h00};
        send_message(msg);
        // Variable identifier as the final byte: length byte missing.
        msg = {8'h00};
        send_message(msg);

        // Double-octet target cut off before its value byte still counts.
        write_target(8'hE5);
        msg = {8'hE5};
        send_message(msg);
        msg = {8'h81, 8'hE5, 8'h33};
        send_message(msg);

        // Top identifier; later copies are ignored, and a double-octet
        // element in front hides an 0xFF value byte from the walk.
        write_target(8'hFF);
        msg = {8'hFF, 8'hFF};
        send_message(msg);
        msg = {8'hE0, 8'hFF, 8'hFF};
        send_message(msg);

        // Truncated variable element is not reported; a complete one is.
        write_target(8'h7F);
        msg = {8'h7F, 8'h03, 8'hAA, 8'hBB};
        send_message(msg);
        msg = {8'h10, 8'h01, 8'h55, 8'h7F, 8'h02, 8'h00, 8'hFF};
        send_message(msg);

        // Random part: cycle through the idle modes, retargeting each phase.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: tgt = 8'h00;
                1: tgt = 8'hFF;
                default: begin
                    case ($urandom_range(3))
                        0: tgt = 8'($urandom_range(255));
                        1: tgt = DOUBLE_CODE | 8'($urandom_range(15));
                        2: tgt = {1'b0, 7'($urandom)};
                        default: tgt = FIXED_MASK | 8'($urandom_range(127));
                    endcase
                end
            endcase
            write_target(tgt);
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 58; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 58; end
                default: begin gap_pct = 21; stall_pct = 21; end
            endcase
            // Back the block up while the sender keeps offering bytes.
            if (ph == 4 || ph == 12) hold_req = HOLD_CYCLES;
            sent = 0;
            while (sent < PHASE_BYTES) begin
                msg = make_message(tgt, (sent == 0) && (ph == 0 || ph == 9));
                send_message(msg);
                sent += msg.size();
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: info_element_locator_top.f
rtl/iel_pkg.sv
rtl/iel_front.sv
rtl/iel_queue.sv
rtl/iel_back.sv
rtl/info_element_locator_top.sv
dv/tb_info_element_locator_top.sv
